>>> hdl/sgcm_pkg.sv
// shared types, widths and codes for the scatter-gather copy merger
package sgcm_pkg;

    localparam int ADDR_BITS = 48;
    localparam int LEN_BITS = 32;
    localparam int OP_BITS = 3;
    localparam int QDEPTH = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [LEN_BITS-1:0] t_len;

    // operation codes on the input channel
    typedef enum logic [OP_BITS-1:0] {
        OP_START   = 3'd0,
        OP_SRC_SEG = 3'd1,
        OP_DST_SEG = 3'd2,
        OP_SRC_END = 3'd3,
        OP_DST_END = 3'd4
    } t_op;

    // item class after decode
    typedef enum logic [2:0] {
        K_START,
        K_SRC_SEG,
        K_DST_SEG,
        K_SRC_END,
        K_DST_END,
        K_BAD
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ACTIVE = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        NEED_NONE = 2'd0,
        NEED_SRC  = 2'd1,
        NEED_DST  = 2'd2
    } t_need;

    // classified item as it travels through the queue
    typedef struct packed {
        t_kind kind;
        t_addr addr;
        t_len  len;
        t_len  offs;
        t_len  cnt;
    } t_item;

    // queue status seen by the front end
    typedef struct packed {
        logic full;
    } t_qstat;

    // push request from the front end
    typedef struct packed {
        logic  push;
        t_item item;
    } t_qpush;

endpackage

>>> hdl/sgcm_front.sv
// front end: accepts input transfers and classifies the operation
module sgcm_front (
    input  logic                                i_valid,
    input  logic [sgcm_pkg::OP_BITS-1:0]        i_operation,
    input  logic [sgcm_pkg::ADDR_BITS-1:0]      i_seg_addr,
    input  logic [sgcm_pkg::LEN_BITS-1:0]       i_seg_length,
    input  logic [sgcm_pkg::LEN_BITS-1:0]       i_start_offset,
    input  logic [sgcm_pkg::LEN_BITS-1:0]       i_byte_count,
    output logic                                o_stall,
    input  sgcm_pkg::t_qstat                    i_qstat,
    output sgcm_pkg::t_qpush                    o_qpush
);

    sgcm_pkg::t_kind kind;

    // decode the operation code into an item class
    always_comb begin
        case (i_operation)
            sgcm_pkg::OP_START:   kind = sgcm_pkg::K_START;
            sgcm_pkg::OP_SRC_SEG: kind = sgcm_pkg::K_SRC_SEG;
            sgcm_pkg::OP_DST_SEG: kind = sgcm_pkg::K_DST_SEG;
            sgcm_pkg::OP_SRC_END: kind = sgcm_pkg::K_SRC_END;
            sgcm_pkg::OP_DST_END: kind = sgcm_pkg::K_DST_END;
            default:              kind = sgcm_pkg::K_BAD;
        endcase
    end

    // stall while the queue is full, push every accepted transfer
    assign o_stall = i_qstat.full;
    assign o_qpush.push = i_valid && !i_qstat.full;
    assign o_qpush.item.kind = kind;
    assign o_qpush.item.addr = i_seg_addr;
    assign o_qpush.item.len = i_seg_length;
    assign o_qpush.item.offs = i_start_offset;
    assign o_qpush.item.cnt = i_byte_count;

endmodule

>>> hdl/sgcm_queue.sv
// short queue between the front end and the back end
module sgcm_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sgcm_pkg::t_qpush  i_qpush,
    output sgcm_pkg::t_qstat  o_qstat,
    output logic              o_head_valid,
    output sgcm_pkg::t_item   o_head,
    input  logic              i_pop
);

    sgcm_pkg::t_item                     r_mem [sgcm_pkg::QDEPTH];
    logic [sgcm_pkg::QPTR_BITS-1:0]      r_wr_ptr;
    logic [sgcm_pkg::QPTR_BITS-1:0]      r_rd_ptr;
    logic [sgcm_pkg::QCNT_BITS-1:0]      r_count;
    logic [sgcm_pkg::QPTR_BITS-1:0]      n_wr_ptr;
    logic [sgcm_pkg::QPTR_BITS-1:0]      n_rd_ptr;
    logic [sgcm_pkg::QCNT_BITS-1:0]      n_count;
    logic                                do_push;
    logic                                do_pop;

    assign o_qstat.full = (r_count == sgcm_pkg::QCNT_BITS'(sgcm_pkg::QDEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head = r_mem[r_rd_ptr];
    assign do_push = i_qpush.push && !o_qstat.full;
    assign do_pop = i_pop && o_head_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!do_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_qpush.item;
        end
    end

endmodule

>>> hdl/sgcm_back.sv
// back end: job state, copy command generation and output register
module sgcm_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_head_valid,
    input  sgcm_pkg::t_item                     i_head,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_copy_valid,
    output logic [sgcm_pkg::ADDR_BITS-1:0]      o_copy_src_addr,
    output logic [sgcm_pkg::ADDR_BITS-1:0]      o_copy_dst_addr,
    output logic [sgcm_pkg::LEN_BITS-1:0]       o_copy_length,
    output logic [1:0]                          o_need_next,
    output logic                                o_job_done,
    output logic [sgcm_pkg::LEN_BITS-1:0]       o_total_copied,
    output logic                                o_protocol_error
);

    // job state
    sgcm_pkg::t_phase r_phase, n_phase;
    sgcm_pkg::t_len   r_bytes_rem, n_bytes_rem;
    sgcm_pkg::t_len   r_skip_rem, n_skip_rem;
    sgcm_pkg::t_addr  r_src_cur, n_src_cur;
    sgcm_pkg::t_len   r_src_left, n_src_left;
    logic             r_src_held, n_src_held;
    sgcm_pkg::t_addr  r_dst_cur, n_dst_cur;
    sgcm_pkg::t_len   r_dst_left, n_dst_left;
    logic             r_dst_held, n_dst_held;
    sgcm_pkg::t_len   r_copied, n_copied;

    // output register
    logic             r_out_valid;
    logic             r_copy_valid, n_copy_valid;
    sgcm_pkg::t_addr  r_copy_src, n_copy_src;
    sgcm_pkg::t_addr  r_copy_dst, n_copy_dst;
    sgcm_pkg::t_len   r_copy_len, n_copy_len;
    sgcm_pkg::t_need  r_need, n_need;
    logic             r_done, n_done;
    logic             r_err, n_err;

    sgcm_pkg::t_need  want;
    sgcm_pkg::t_len   min_a;
    sgcm_pkg::t_len   copy_n;
    sgcm_pkg::t_len   src_after;
    sgcm_pkg::t_len   dst_after;
    sgcm_pkg::t_len   bytes_after;

    // take the queue head whenever the output register is free or draining
    assign o_pop = i_head_valid && (!r_out_valid || !i_stall);

    // descriptor kind wanted by the current state
    always_comb begin
        if (r_phase != sgcm_pkg::PH_ACTIVE) begin
            want = sgcm_pkg::NEED_NONE;
        end else if (!r_src_held) begin
            want = sgcm_pkg::NEED_SRC;
        end else if (!r_dst_held) begin
            want = sgcm_pkg::NEED_DST;
        end else begin
            want = sgcm_pkg::NEED_NONE;
        end
    end

    // copy size is the least of remaining, source left and new destination length
    assign min_a = (r_src_left < r_bytes_rem) ? r_src_left : r_bytes_rem;
    assign copy_n = (i_head.len < min_a) ? i_head.len : min_a;
    assign src_after = r_src_left - copy_n;
    assign dst_after = i_head.len - copy_n;
    assign bytes_after = r_bytes_rem - copy_n;

    // next state and result for the head item
    always_comb begin
        n_phase = r_phase;
        n_bytes_rem = r_bytes_rem;
        n_skip_rem = r_skip_rem;
        n_src_cur = r_src_cur;
        n_src_left = r_src_left;
        n_src_held = r_src_held;
        n_dst_cur = r_dst_cur;
        n_dst_left = r_dst_left;
        n_dst_held = r_dst_held;
        n_copied = r_copied;
        n_copy_valid = 1'b0;
        n_copy_src = '0;
        n_copy_dst = '0;
        n_copy_len = '0;
        n_err = 1'b0;
        case (i_head.kind)
            sgcm_pkg::K_START: begin
                n_phase = (i_head.cnt == '0) ? sgcm_pkg::PH_DONE : sgcm_pkg::PH_ACTIVE;
                n_bytes_rem = i_head.cnt;
                n_skip_rem = i_head.offs;
                n_src_held = 1'b0;
                n_dst_held = 1'b0;
                n_src_left = '0;
                n_dst_left = '0;
                n_copied = '0;
            end
            sgcm_pkg::K_SRC_SEG: begin
                if (want != sgcm_pkg::NEED_SRC) begin
                    n_err = 1'b1;
                end else if (r_skip_rem >= i_head.len) begin
                    n_skip_rem = r_skip_rem - i_head.len;
                end else begin
                    n_src_cur = i_head.addr + sgcm_pkg::t_addr'(r_skip_rem);
                    n_src_left = i_head.len - r_skip_rem;
                    n_skip_rem = '0;
                    n_src_held = 1'b1;
                end
            end
            sgcm_pkg::K_DST_SEG: begin
                if (want != sgcm_pkg::NEED_DST) begin
                    n_err = 1'b1;
                end else if (i_head.len != '0) begin
                    // a source is held here, so the copy always goes out
                    n_copy_valid = 1'b1;
                    n_copy_src = r_src_cur;
                    n_copy_dst = i_head.addr;
                    n_copy_len = copy_n;
                    n_src_cur = r_src_cur + sgcm_pkg::t_addr'(copy_n);
                    n_dst_cur = i_head.addr + sgcm_pkg::t_addr'(copy_n);
                    n_src_left = src_after;
                    n_dst_left = dst_after;
                    n_bytes_rem = bytes_after;
                    n_copied = r_copied + copy_n;
                    n_src_held = (src_after != '0);
                    n_dst_held = (dst_after != '0);
                    if (bytes_after == '0) begin
                        n_phase = sgcm_pkg::PH_DONE;
                        n_src_held = 1'b0;
                        n_dst_held = 1'b0;
                    end
                end
            end
            sgcm_pkg::K_SRC_END: begin
                if (want != sgcm_pkg::NEED_SRC) begin
                    n_err = 1'b1;
                end else begin
                    n_phase = sgcm_pkg::PH_DONE;
                    n_src_held = 1'b0;
                    n_dst_held = 1'b0;
                end
            end
            sgcm_pkg::K_DST_END: begin
                if (want != sgcm_pkg::NEED_DST) begin
                    n_err = 1'b1;
                end else begin
                    n_phase = sgcm_pkg::PH_DONE;
                    n_src_held = 1'b0;
                    n_dst_held = 1'b0;
                end
            end
            default: begin
                n_err = 1'b1;
            end
        endcase

        // status reported from the state after this item
        if (n_phase != sgcm_pkg::PH_ACTIVE) begin
            n_need = sgcm_pkg::NEED_NONE;
        end else if (!n_src_held) begin
            n_need = sgcm_pkg::NEED_SRC;
        end else if (!n_dst_held) begin
            n_need = sgcm_pkg::NEED_DST;
        end else begin
            n_need = sgcm_pkg::NEED_NONE;
        end
        n_done = (n_phase == sgcm_pkg::PH_DONE);
    end

    // state registers advance on each popped item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sgcm_pkg::PH_IDLE;
            r_bytes_rem <= '0;
            r_skip_rem <= '0;
            r_src_cur <= '0;
            r_src_left <= '0;
            r_src_held <= 1'b0;
            r_dst_cur <= '0;
            r_dst_left <= '0;
            r_dst_held <= 1'b0;
            r_copied <= '0;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_bytes_rem <= n_bytes_rem;
            r_skip_rem <= n_skip_rem;
            r_src_cur <= n_src_cur;
            r_src_left <= n_src_left;
            r_src_held <= n_src_held;
            r_dst_cur <= n_dst_cur;
            r_dst_left <= n_dst_left;
            r_dst_held <= n_dst_held;
            r_copied <= n_copied;
        end
    end

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_copy_valid <= n_copy_valid;
            r_copy_src <= n_copy_src;
            r_copy_dst <= n_copy_dst;
            r_copy_len <= n_copy_len;
            r_need <= n_need;
            r_done <= n_done;
            r_err <= n_err;
        end
    end

    assign o_valid = r_out_valid;
    assign o_copy_valid = r_copy_valid;
    assign o_copy_src_addr = r_copy_src;
    assign o_copy_dst_addr = r_copy_dst;
    assign o_copy_length = r_copy_len;
    assign o_need_next = r_need;
    assign o_job_done = r_done;
    assign o_total_copied = r_copied;
    assign o_protocol_error = r_err;

endmodule

>>> hdl/scatter_gather_copy_merger.sv
// top level of the scatter-gather copy merger
//
// Input channel (i_valid / o_stall): one descriptor item per transfer: a
// start (offset and byte count), a source or destination segment, or the
// end of either list. Output channel (o_valid / i_stall): exactly one result
// per input item, in order, carrying an optional copy command, the kind of
// descriptor wanted next, the done flag, the running total and an error flag.
// Throughput is one item per cycle while the receiver does not stall; the
// back end updates the job state for one queued item each cycle unless the
// output register is held, its longest path being the three-way minimum
// followed by the cursor add. An accepted item is stored in the queue and
// then popped into the output register. A four-entry queue sits between the
// decode front end and the back end. When the receiver stalls, the output
// register holds its result, the queue fills, and o_stall rises once all four
// entries are used. Synchronous reset empties the queue and output register
// and puts the job state to idle with all counts and cursors zero.
module scatter_gather_copy_merger (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [sgcm_pkg::OP_BITS-1:0]        i_operation,
    input  logic [sgcm_pkg::ADDR_BITS-1:0]      i_seg_addr,
    input  logic [sgcm_pkg::LEN_BITS-1:0]       i_seg_length,
    input  logic [sgcm_pkg::LEN_BITS-1:0]       i_start_offset,
    input  logic [sgcm_pkg::LEN_BITS-1:0]       i_byte_count,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_copy_valid,
    output logic [sgcm_pkg::ADDR_BITS-1:0]      o_copy_src_addr,
    output logic [sgcm_pkg::ADDR_BITS-1:0]      o_copy_dst_addr,
    output logic [sgcm_pkg::LEN_BITS-1:0]       o_copy_length,
    output logic [1:0]                          o_need_next,
    output logic                                o_job_done,
    output logic [sgcm_pkg::LEN_BITS-1:0]       o_total_copied,
    output logic                                o_protocol_error
);

    sgcm_pkg::t_qpush qpush;
    sgcm_pkg::t_qstat qstat;
    logic             head_valid;
    sgcm_pkg::t_item  head;
    logic             pop;

    // decode and accept
    sgcm_front u_front (
        .i_valid        (i_valid),
        .i_operation    (i_operation),
        .i_seg_addr     (i_seg_addr),
        .i_seg_length   (i_seg_length),
        .i_start_offset (i_start_offset),
        .i_byte_count   (i_byte_count),
        .o_stall        (o_stall),
        .i_qstat        (qstat),
        .o_qpush        (qpush)
    );

    // item queue
    sgcm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_qpush      (qpush),
        .o_qstat      (qstat),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    // job state and results
    sgcm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (head_valid),
        .i_head           (head),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_copy_valid     (o_copy_valid),
        .o_copy_src_addr  (o_copy_src_addr),
        .o_copy_dst_addr  (o_copy_dst_addr),
        .o_copy_length    (o_copy_length),
        .o_need_next      (o_need_next),
        .o_job_done       (o_job_done),
        .o_total_copied   (o_total_copied),
        .o_protocol_error (o_protocol_error)
    );

endmodule

>>> sim/sgcm_copy_tracker.sv
// checker that predicts copy merger results and compares them with the dut
module sgcm_copy_tracker
    import sgcm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [OP_BITS-1:0]     i_operation,
    input  logic [ADDR_BITS-1:0]   i_seg_addr,
    input  logic [LEN_BITS-1:0]    i_seg_length,
    input  logic [LEN_BITS-1:0]    i_start_offset,
    input  logic [LEN_BITS-1:0]    i_byte_count,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic                   i_copy_valid,
    input  logic [ADDR_BITS-1:0]   i_copy_src_addr,
    input  logic [ADDR_BITS-1:0]   i_copy_dst_addr,
    input  logic [LEN_BITS-1:0]    i_copy_length,
    input  logic [1:0]             i_need_next,
    input  logic                   i_job_done,
    input  logic [LEN_BITS-1:0]    i_total_copied,
    input  logic                   i_protocol_error,
    output int                     o_mismatches,
    output int                     o_pending,
    output t_need                  o_need
);
    timeunit 1ns;
    timeprecision 1ps;

    // one result as the block reports it
    typedef struct {
        logic       copy_valid;
        t_addr      src;
        t_addr      dst;
        t_len       length;
        logic [1:0] need;
        logic       done;
        t_len       total;
        logic       err;
    } copy_result_t;

    copy_result_t expected_results[$];

    // predicted job state
    t_phase job_state;
    t_len   left_to_copy;
    t_len   skip_left;
    t_addr  src_cursor;
    t_len   src_avail;
    logic   src_loaded;
    t_addr  dst_cursor;
    t_len   dst_avail;
    logic   dst_loaded;
    t_len   copied_sum;

    // descriptor kind the job asks for next
    function automatic t_need wanted_kind();
        if (job_state != PH_ACTIVE) return NEED_NONE;
        if (!src_loaded) return NEED_SRC;
        if (!dst_loaded) return NEED_DST;
        return NEED_NONE;
    endfunction

    task automatic close_job();
        job_state  = PH_DONE;
        src_loaded = 1'b0;
        dst_loaded = 1'b0;
    endtask

    // apply one accepted item to the job and build its result
    task automatic advance_job(input logic [OP_BITS-1:0] op, input t_addr addr,
                               input t_len len, input t_len offs, input t_len cnt,
                               output copy_result_t res);
        t_need want;
        t_len  n;
        want = wanted_kind();
        res.copy_valid = 1'b0;
        res.src        = '0;
        res.dst        = '0;
        res.length     = '0;
        res.err        = 1'b0;
        case (op)
            OP_START: begin
                job_state    = PH_ACTIVE;
                left_to_copy = cnt;
                skip_left    = offs;
                src_loaded   = 1'b0;
                dst_loaded   = 1'b0;
                src_avail    = '0;
                dst_avail    = '0;
                copied_sum   = '0;
                if (cnt == '0) close_job();
            end
            OP_SRC_SEG: begin
                if (want != NEED_SRC) begin
                    res.err = 1'b1;
                end else if (skip_left >= len) begin
                    // whole segment lies inside the start offset
                    skip_left = skip_left - len;
                end else begin
                    src_cursor = addr + t_addr'(skip_left);
                    src_avail  = len - skip_left;
                    skip_left  = '0;
                    src_loaded = 1'b1;
                end
            end
            OP_DST_SEG: begin
                if (want != NEED_DST) begin
                    res.err = 1'b1;
                end else if (len != '0) begin
                    dst_cursor = addr;
                    dst_avail  = len;
                    dst_loaded = 1'b1;
                    // copy the least of remaining, source left and destination left
                    n = left_to_copy;
                    if (src_avail < n) n = src_avail;
                    if (dst_avail < n) n = dst_avail;
                    res.copy_valid = 1'b1;
                    res.src        = src_cursor;
                    res.dst        = dst_cursor;
                    res.length     = n;
                    src_cursor     = src_cursor + t_addr'(n);
                    dst_cursor     = dst_cursor + t_addr'(n);
                    src_avail      = src_avail - n;
                    dst_avail      = dst_avail - n;
                    left_to_copy   = left_to_copy - n;
                    copied_sum     = copied_sum + n;
                    if (src_avail == '0) src_loaded = 1'b0;
                    if (dst_avail == '0) dst_loaded = 1'b0;
                    if (left_to_copy == '0) close_job();
                end
            end
            OP_SRC_END: begin
                if (want != NEED_SRC) res.err = 1'b1;
                else close_job();
            end
            OP_DST_END: begin
                if (want != NEED_DST) res.err = 1'b1;
                else close_job();
            end
            default: res.err = 1'b1;
        endcase
        res.need  = wanted_kind();
        res.done  = (job_state == PH_DONE);
        res.total = copied_sum;
    endtask

    function automatic void show_result(string tag, copy_result_t r);
        $display("  %s copy=%0b src=%h dst=%h len=%h need=%0d done=%0b total=%h err=%0b",
                 tag, r.copy_valid, r.src, r.dst, r.length, r.need, r.done, r.total, r.err);
    endfunction

    // watch both channels at each rising edge
    always @(posedge i_clk) begin : watch_channels
        copy_result_t exp_r;
        copy_result_t got_r;
        copy_result_t new_r;
        if (!i_rst_n) begin
            job_state    = PH_IDLE;
            left_to_copy = '0;
            skip_left    = '0;
            src_cursor   = '0;
            src_avail    = '0;
            src_loaded   = 1'b0;
            dst_cursor   = '0;
            dst_avail    = '0;
            dst_loaded   = 1'b0;
            copied_sum   = '0;
            expected_results.delete();
            o_mismatches = 0;
        end else begin
            // result transfer against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                got_r.copy_valid = i_copy_valid;
                got_r.src        = i_copy_src_addr;
                got_r.dst        = i_copy_dst_addr;
                got_r.length     = i_copy_length;
                got_r.need       = i_need_next;
                got_r.done       = i_job_done;
                got_r.total      = i_total_copied;
                got_r.err        = i_protocol_error;
                if (expected_results.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10) begin
                        $display("%0t: result with no item outstanding", $realtime);
                        show_result("got     ", got_r);
                    end
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got_r.copy_valid !== exp_r.copy_valid || got_r.src !== exp_r.src ||
                        got_r.dst !== exp_r.dst || got_r.length !== exp_r.length ||
                        got_r.need !== exp_r.need || got_r.done !== exp_r.done ||
                        got_r.total !== exp_r.total || got_r.err !== exp_r.err) begin
                        o_mismatches++;
                        if (o_mismatches <= 10) begin
                            $display("%0t: result mismatch", $realtime);
                            show_result("expected", exp_r);
                            show_result("got     ", got_r);
                        end
                    end
                end
            end
            // item transfer into the prediction
            if (i_in_valid && !i_in_stall) begin
                advance_job(i_operation, i_seg_addr, i_seg_length, i_start_offset,
                            i_byte_count, new_r);
                expected_results.push_back(new_r);
            end
        end
        o_pending = expected_results.size();
        o_need    = wanted_kind();
    end

endmodule

>>> sim/scatter_gather_copy_merger_tb.sv
// testbench top for the scatter-gather copy merger: stimulus and verdict
module scatter_gather_copy_merger_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sgcm_pkg::*;

    localparam int N_RANDOM     = 1400;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [OP_BITS-1:0]   i_operation;
    logic [ADDR_BITS-1:0] i_seg_addr;
    logic [LEN_BITS-1:0]  i_seg_length;
    logic [LEN_BITS-1:0]  i_start_offset;
    logic [LEN_BITS-1:0]  i_byte_count;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_copy_valid;
    logic [ADDR_BITS-1:0] o_copy_src_addr;
    logic [ADDR_BITS-1:0] o_copy_dst_addr;
    logic [LEN_BITS-1:0]  o_copy_length;
    logic [1:0]           o_need_next;
    logic                 o_job_done;
    logic [LEN_BITS-1:0]  o_total_copied;
    logic                 o_protocol_error;

    int    mismatches;
    int    pending;
    t_need next_need;

    // sender pacing and receiver hold-off request
    bit send_burst;
    int send_burst_left;
    int fast_items;
    bit hold_off_req;

    scatter_gather_copy_merger dut (.*);

    sgcm_copy_tracker tracker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_operation      (i_operation),
        .i_seg_addr       (i_seg_addr),
        .i_seg_length     (i_seg_length),
        .i_start_offset   (i_start_offset),
        .i_byte_count     (i_byte_count),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_copy_valid     (o_copy_valid),
        .i_copy_src_addr  (o_copy_src_addr),
        .i_copy_dst_addr  (o_copy_dst_addr),
        .i_copy_length    (o_copy_length),
        .i_need_next      (o_need_next),
        .i_job_done       (o_job_done),
        .i_total_copied   (o_total_copied),
        .i_protocol_error (o_protocol_error),
        .o_mismatches     (mismatches),
        .o_pending        (pending),
        .o_need           (next_need)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // random field values, biased toward small sizes and the extremes
    function automatic t_addr pick_addr();
        if ($urandom_range(0, 7) == 0) return '1 - t_addr'($urandom_range(0, 64));
        return t_addr'({$urandom, $urandom});
    endfunction

    function automatic t_len pick_len();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return t_len'($urandom);
            default: return t_len'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic t_len pick_offset();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return '0;
            4: return t_len'($urandom);
            5: return '1;
            default: return t_len'($urandom_range(0, 100));
        endcase
    endfunction

    function automatic t_len pick_count();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return t_len'($urandom);
            default: return t_len'($urandom_range(1, 300));
        endcase
    endfunction

    // offer one item after a random gap and hold it until the transfer
    task automatic send_item(input logic [OP_BITS-1:0] op, input t_addr addr,
                             input t_len len, input t_len offs, input t_len cnt);
        int gap;
        if (send_burst_left <= 0) begin
            send_burst      = ($urandom_range(0, 3) == 0);
            send_burst_left = $urandom_range(20, 80);
        end
        send_burst_left--;
        gap = (send_burst || fast_items > 0) ? 0 : $urandom_range(0, 19);
        if (fast_items > 0) fast_items--;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_seg_addr     <= addr;
        i_seg_length   <= len;
        i_start_offset <= offs;
        i_byte_count   <= cnt;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // result side: random stall before each transfer, one long hold-off on request
    initial begin : result_sink
        int gap;
        int burst_left;
        bit burst;
        i_stall    = 1'b0;
        burst_left = 0;
        burst      = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (burst_left <= 0) begin
                burst      = ($urandom_range(0, 3) == 0);
                burst_left = $urandom_range(20, 80);
            end
            burst_left--;
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            gap = burst ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    // watchdog on cycles without any transfer
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n && ((i_valid && !o_stall) || (o_valid && !i_stall))) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("scatter_gather_copy_merger_tb: FAIL");
        $finish;
    end

    // stimulus and verdict
    initial begin : stimulus
        int useful;
        int roll;
        bit pressure_done;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_operation     = OP_START;
        i_seg_addr      = '0;
        i_seg_length    = '0;
        i_start_offset  = '0;
        i_byte_count    = '0;
        send_burst      = 1'b0;
        send_burst_left = 0;
        fast_items      = 0;
        hold_off_req    = 1'b0;
        pressure_done   = 1'b0;
        useful          = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: refused items, zero count, extremes, wrap, skipping, list ends
        send_item(OP_SRC_SEG, 48'h1000, 32'd16, '0, '0);
        send_item(3'd5, '1, '1, '1, '1);
        send_item(3'd7, '0, '0, '0, '0);
        send_item(OP_START, '0, '0, 32'd7, '0);
        send_item(OP_DST_SEG, 48'h2000, 32'd8, '0, '0);
        send_item(OP_START, '0, '0, '0, '1);
        send_item(OP_DST_SEG, 48'h2000, 32'd8, '0, '0);
        send_item(OP_SRC_SEG, 48'hFFFF_FFFF_FFF0, '0, '0, '0);
        send_item(OP_SRC_SEG, 48'hFFFF_FFFF_FFF0, 32'h40, '0, '0);
        send_item(OP_DST_SEG, 48'h2000, '0, '0, '0);
        send_item(OP_DST_SEG, 48'hFFFF_FFFF_FFE0, '1, '0, '0);
        send_item(OP_SRC_SEG, '0, '1, '0, '0);
        send_item(OP_SRC_END, '0, '0, '0, '0);
        // start while segments are held, then skip into the source list
        send_item(OP_START, '0, '0, 32'd12, 32'd100);
        send_item(OP_SRC_SEG, 48'h3000, 32'd4, '0, '0);
        send_item(OP_SRC_SEG, 48'h3100, 32'd6, '0, '0);
        send_item(OP_SRC_SEG, 48'h3200, 32'd50, '0, '0);
        send_item(OP_DST_SEG, 48'h5000, 32'd30, '0, '0);
        send_item(OP_DST_END, '0, '0, '0, '0);
        send_item(OP_START, '0, '0, '1, '1);
        send_item(OP_SRC_SEG, '1, '1, '1, '1);
        send_item(OP_SRC_END, '0, '0, '0, '0);
        send_item(OP_START, '0, '0, '0, 32'd5);
        send_item(OP_SRC_SEG, 48'h7000, 32'd100, '0, '0);
        send_item(OP_DST_SEG, 48'h9000, 32'd100, '0, '0);

        // random: mostly in-turn jobs with random content, some noise
        while (useful < N_RANDOM) begin
            if (useful == N_RANDOM / 2 && !pressure_done) begin
                pressure_done = 1'b1;
                hold_off_req  = 1'b1;
                fast_items    = 60;
            end
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                send_item(OP_BITS'($urandom_range(0, 7)), pick_addr(), pick_len(),
                          $urandom, $urandom);
            end else begin
                useful++;
                if (next_need == NEED_NONE) begin
                    send_item(OP_START, pick_addr(), pick_len(), pick_offset(), pick_count());
                end else if (next_need == NEED_SRC) begin
                    if (roll < 20) send_item(OP_SRC_END, pick_addr(), pick_len(), $urandom, $urandom);
                    else send_item(OP_SRC_SEG, pick_addr(), pick_len(), $urandom, $urandom);
                end else begin
                    if (roll < 20) send_item(OP_DST_END, pick_addr(), pick_len(), $urandom, $urandom);
                    else if (roll < 26) send_item(OP_DST_SEG, pick_addr(), '0, $urandom, $urandom);
                    else send_item(OP_DST_SEG, pick_addr(), pick_len(), $urandom, $urandom);
                end
            end
        end
        i_valid <= 1'b0;

        // drain outstanding results and let the design idle before the verdict
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("scatter_gather_copy_merger_tb: PASS");
        end else begin
            $display("scatter_gather_copy_merger_tb: FAIL");
        end
        $finish;
    end

endmodule
